### rtl/block_buffer_cache_lru_assert.svh
// assertion macros shared by the cache rtl
`ifndef BLOCK_BUFFER_CACHE_LRU_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LRU_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbc assertion failed");

// next-cycle implication, checked out of reset
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbc assertion failed");

`endif

### rtl/bbc_pkg.sv
`timescale 1ns / 1ps
package bbc_pkg;

    typedef enum logic [2:0] {
        OP_GET        = 3'd0,
        OP_RELEASE    = 3'd1,
        OP_PIN        = 3'd2,
        OP_UNPIN      = 3'd3,
        OP_MARK_VALID = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREE   = 2'd1,
        STAT_COUNT_ERR = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SCAN,
        CS_DRAIN,
        CS_READ,
        CS_DECIDE
    } ctl_state_t;

    typedef struct packed {
        logic [15:0] dev;
        logic [31:0] blk;
        logic [7:0]  refs;
        logic [31:0] rtime;
        logic        dv;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan_issue;
        logic entry_issue;
        logic commit;
    } bbc_cmd_t;

    typedef struct packed {
        logic scan_last;
    } bbc_sts_t;

    localparam logic [7:0] REFS_MAX = 8'hFF;

endpackage

### rtl/bbc_if.sv
`timescale 1ns / 1ps
interface bbc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [15:0] device;
    logic [31:0] block_number;
    logic [4:0]  entry;
    logic [31:0] now;

    modport source (output valid, output op, output device, output block_number,
                    output entry, output now, input ready);
    modport sink (input valid, input op, input device, input block_number,
                  input entry, input now, output ready);
endinterface

interface bbc_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] slot;
    logic       hit;
    logic       needs_read;
    logic [7:0] ref_count;
    logic [1:0] status;

    modport source (output valid, output slot, output hit, output needs_read,
                    output ref_count, output status, input ready);
    modport sink (input valid, input slot, input hit, input needs_read,
                  input ref_count, input status, output ready);
endinterface

### rtl/bbc_ctrl.sv
`timescale 1ns / 1ps
module bbc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_get,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bbc_pkg::bbc_sts_t sts,
    output bbc_pkg::bbc_cmd_t cmd
);
    import bbc_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = in_get ? CS_SCAN : CS_READ;
                end
            end
            CS_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = CS_DRAIN;
                end
            end
            CS_DRAIN:
            begin
                state_next = CS_DECIDE;
            end
            CS_READ:
            begin
                cmd.entry_issue = 1'b1;
                state_next      = CS_DECIDE;
            end
            CS_DECIDE:
            begin
                // hold the decision until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/bbc_dpath.sv
`timescale 1ns / 1ps
module bbc_dpath #(
    parameter int BUFFERS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bbc_pkg::bbc_cmd_t cmd,
    output bbc_pkg::bbc_sts_t sts,
    input  logic [2:0]        op,
    input  logic [15:0]       device,
    input  logic [31:0]       block_number,
    input  logic [4:0]        entry,
    input  logic [31:0]       now,
    output logic [4:0]        slot,
    output logic              hit,
    output logic              needs_read,
    output logic [7:0]        ref_count,
    output logic [1:0]        status
);
    import bbc_pkg::*;

    localparam int IDX_W = $clog2(BUFFERS);

    entry_t               mem [BUFFERS];
    logic [BUFFERS-1:0]   vld_reg;

    logic [2:0]           op_reg;
    logic [15:0]          dev_reg;
    logic [31:0]          blk_reg;
    logic [4:0]           entry_reg;
    logic [31:0]          now_reg;

    logic [IDX_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     raddr;
    logic [IDX_W-1:0]     ridx_reg;
    logic                 rvalid_reg;
    entry_t               rd_reg;
    logic                 rd_ok_reg;
    entry_t               ent;

    logic                 m_found_reg;
    logic [IDX_W-1:0]     m_idx_reg;
    logic [7:0]           m_refs_reg;
    logic [31:0]          m_time_reg;
    logic                 m_dv_reg;
    logic                 v_found_reg;
    logic [IDX_W-1:0]     v_idx_reg;
    logic [31:0]          v_time_reg;

    logic                 ent_match;
    logic                 ent_free;
    logic                 in_range;

    logic                 wr_req;
    logic [IDX_W-1:0]     waddr;
    entry_t               wdata;
    logic [4:0]           res_slot;
    logic                 res_hit;
    logic                 res_nr;
    logic [7:0]           res_cnt;
    stat_t                res_stat;
    logic [7:0]           refs_inc;
    logic [7:0]           refs_dec;

    logic [4:0]           slot_reg;
    logic                 hit_reg;
    logic                 nr_reg;
    logic [7:0]           cnt_out_reg;
    logic [1:0]           stat_reg;

    assign raddr         = cmd.scan_issue ? cnt_reg : IDX_W'(entry_reg);
    assign sts.scan_last = (cnt_reg == IDX_W'(BUFFERS - 1));
    // entries never written read as the reset value
    assign ent           = rd_ok_reg ? rd_reg : '0;
    assign ent_match     = (ent.dev == dev_reg) && (ent.blk == blk_reg);
    assign ent_free      = (ent.refs == 8'd0);
    assign in_range      = ({27'd0, entry_reg} < 32'(BUFFERS));
    assign refs_inc      = ent.refs + 8'd1;
    assign refs_dec      = ent.refs - 8'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_issue || cmd.entry_issue)
        begin
            rd_reg    <= mem[raddr];
            rd_ok_reg <= vld_reg[raddr];
        end
        if (cmd.commit && wr_req)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            dev_reg   <= device;
            blk_reg   <= block_number;
            entry_reg <= entry;
            now_reg   <= now;
        end
        ridx_reg <= cnt_reg;
        if (rvalid_reg && ent_match && !m_found_reg)
        begin
            m_idx_reg  <= ridx_reg;
            m_refs_reg <= ent.refs;
            m_time_reg <= ent.rtime;
            m_dv_reg   <= ent.dv;
        end
        if (rvalid_reg && ent_free && (!v_found_reg || ent.rtime < v_time_reg))
        begin
            v_idx_reg  <= ridx_reg;
            v_time_reg <= ent.rtime;
        end
        if (cmd.commit)
        begin
            slot_reg    <= res_slot;
            hit_reg     <= res_hit;
            nr_reg      <= res_nr;
            cnt_out_reg <= res_cnt;
            stat_reg    <= res_stat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            cnt_reg     <= '0;
            rvalid_reg  <= 1'b0;
            m_found_reg <= 1'b0;
            v_found_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= cmd.scan_issue;
            if (cmd.load)
            begin
                cnt_reg     <= '0;
                m_found_reg <= 1'b0;
                v_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_issue)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (rvalid_reg && ent_match)
                begin
                    m_found_reg <= 1'b1;
                end
                if (rvalid_reg && ent_free)
                begin
                    v_found_reg <= 1'b1;
                end
            end
            if (cmd.commit && wr_req)
            begin
                vld_reg[waddr] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        wr_req   = 1'b0;
        waddr    = IDX_W'(entry_reg);
        wdata    = ent;
        res_slot = entry_reg;
        res_hit  = 1'b0;
        res_nr   = !ent.dv;
        res_cnt  = ent.refs;
        res_stat = STAT_OK;
        if (op_reg == OP_GET)
        begin
            if (m_found_reg)
            begin
                res_slot = 5'(m_idx_reg);
                res_hit  = 1'b1;
                res_nr   = !m_dv_reg;
                res_cnt  = m_refs_reg;
                if (m_refs_reg == REFS_MAX)
                begin
                    res_stat = STAT_COUNT_ERR;
                end
                else
                begin
                    res_cnt = m_refs_reg + 8'd1;
                    wr_req  = 1'b1;
                    waddr   = m_idx_reg;
                    wdata   = '{dev: dev_reg, blk: blk_reg, refs: res_cnt,
                                rtime: m_time_reg, dv: m_dv_reg};
                end
            end
            else if (v_found_reg)
            begin
                res_slot = 5'(v_idx_reg);
                res_nr   = 1'b1;
                res_cnt  = 8'd1;
                wr_req   = 1'b1;
                waddr    = v_idx_reg;
                wdata    = '{dev: dev_reg, blk: blk_reg, refs: 8'd1,
                             rtime: v_time_reg, dv: 1'b0};
            end
            else
            begin
                res_slot = 5'd0;
                res_nr   = 1'b0;
                res_cnt  = 8'd0;
                res_stat = STAT_NO_FREE;
            end
        end
        else if (!in_range)
        begin
            res_nr  = 1'b0;
            res_cnt = 8'd0;
            if (op_reg == OP_RELEASE || op_reg == OP_PIN || op_reg == OP_UNPIN ||
                op_reg == OP_MARK_VALID)
            begin
                res_stat = STAT_COUNT_ERR;
            end
        end
        else
        begin
            unique case (op_reg)
                OP_RELEASE, OP_UNPIN:
                begin
                    if (ent_free)
                    begin
                        res_stat = STAT_COUNT_ERR;
                    end
                    else
                    begin
                        res_cnt    = refs_dec;
                        wr_req     = 1'b1;
                        wdata.refs = refs_dec;
                        // last release stamps the time for replacement order
                        if (op_reg == OP_RELEASE && refs_dec == 8'd0)
                        begin
                            wdata.rtime = now_reg;
                        end
                    end
                end
                OP_PIN:
                begin
                    if (ent.refs == REFS_MAX)
                    begin
                        res_stat = STAT_COUNT_ERR;
                    end
                    else
                    begin
                        res_cnt    = refs_inc;
                        wr_req     = 1'b1;
                        wdata.refs = refs_inc;
                    end
                end
                OP_MARK_VALID:
                begin
                    res_nr   = 1'b0;
                    wr_req   = 1'b1;
                    wdata.dv = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign slot       = slot_reg;
    assign hit        = hit_reg;
    assign needs_read = nr_reg;
    assign ref_count  = cnt_out_reg;
    assign status     = stat_reg;

endmodule

### rtl/block_buffer_cache_lru.sv
`timescale 1ns / 1ps
// channel  dir  payload
// req      in   op, device, block_number, entry, now
// rsp      out  slot, hit, needs_read, ref_count, status
//
// one item at a time: a get scans every entry, one entry a cycle, through the single
// read port of the entry memory and then decides; release, pin, unpin and mark valid
// read only the addressed entry.
// reset leaves every entry reading as zero through per-entry valid flags; no
// clearing pass, items are taken right after reset.
// a result waits in its output register while the next item is already taken.
module block_buffer_cache_lru #(
    parameter int BUFFERS = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    bbc_req_if.sink  req,
    bbc_rsp_if.source rsp
);
    import bbc_pkg::*;

    bbc_cmd_t cmd;
    bbc_sts_t sts;
    logic     in_get;

    assign in_get = (req.op == OP_GET);

    bbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_get    (in_get),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bbc_dpath #(
        .BUFFERS (BUFFERS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .op           (req.op),
        .device       (req.device),
        .block_number (req.block_number),
        .entry        (req.entry),
        .now          (req.now),
        .slot         (rsp.slot),
        .hit          (rsp.hit),
        .needs_read   (rsp.needs_read),
        .ref_count    (rsp.ref_count),
        .status       (rsp.status)
    );

`include "block_buffer_cache_lru_assert.svh"

    `BBC_ASSERT_NEXT(a_one_item, clk, rst_n, req.valid && req.ready, !req.ready)
    `BBC_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.commit, !rsp.valid || rsp.ready)
    `BBC_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, rsp.valid)
    `BBC_ASSERT_IMPL(a_single_cmd, clk, rst_n, 1'b1, $onehot0(cmd))

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
    import bbc_pkg::*;

    localparam int N_BUF = 32;
    localparam int TARGET_ITEMS = 1050;
    localparam int SETTLE_CYCLES = 48;
    localparam int MIXED_RUN = 150;
    // op codes the block leaves undefined
    localparam logic [2:0] OP_RSVD_LO  = 3'd5;
    localparam logic [2:0] OP_RSVD_MID = 3'd6;
    localparam logic [2:0] OP_RSVD_HI  = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] device;
        logic [31:0] blk;
        logic [4:0]  entry;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [4:0] slot;
        logic       hit;
        logic       needs_read;
        logic [7:0] ref_count;
        logic [1:0] status;
    } rsp_t;

    class cache_scoreboard;
        logic [15:0] tag_dev [N_BUF];
        logic [31:0] tag_blk [N_BUF];
        logic [7:0]  refs [N_BUF];
        logic [31:0] rel_time [N_BUF];
        logic        dv [N_BUF];
        rsp_t        pending_rsp [$];
        int errors;
        int n_hit;
        int n_alloc;
        int n_full;
        int n_count_err;
        int n_checked;

        function new();
            foreach (refs[i])
            begin
                tag_dev[i] = '0;
                tag_blk[i] = '0;
                refs[i] = '0;
                rel_time[i] = '0;
                dv[i] = 1'b0;
            end
            errors = 0;
            n_hit = 0;
            n_alloc = 0;
            n_full = 0;
            n_count_err = 0;
            n_checked = 0;
        endfunction

        // updates the tag store and returns the response one request earns
        function rsp_t apply_request(req_t rq);
            rsp_t r;
            int match;
            int victim;
            int e;
            logic [31:0] oldest;
            r = '0;
            r.slot = rq.entry;
            r.status = STAT_OK;
            if (rq.op == OP_GET)
            begin
                match = -1;
                for (int i = 0; i < N_BUF; i++)
                    if (match < 0 && tag_dev[i] == rq.device && tag_blk[i] == rq.blk)
                        match = i;
                if (match >= 0)
                begin
                    r.slot = 5'(match);
                    r.hit = 1'b1;
                    r.needs_read = !dv[match];
                    if (refs[match] == REFS_MAX)
                        r.status = STAT_COUNT_ERR;
                    else
                        refs[match] = refs[match] + 8'd1;
                    r.ref_count = refs[match];
                    return r;
                end
                victim = -1;
                oldest = '0;
                for (int i = 0; i < N_BUF; i++)
                    if (refs[i] == 0 && (victim < 0 || rel_time[i] < oldest))
                    begin
                        victim = i;
                        oldest = rel_time[i];
                    end
                if (victim < 0)
                begin
                    r.slot = '0;
                    r.status = STAT_NO_FREE;
                    return r;
                end
                tag_dev[victim] = rq.device;
                tag_blk[victim] = rq.blk;
                refs[victim] = 8'd1;
                dv[victim] = 1'b0;
                r.slot = 5'(victim);
                r.needs_read = 1'b1;
                r.ref_count = 8'd1;
                return r;
            end
            // entry is 5 bits wide, so with 32 buffers it is always in range
            e = int'(rq.entry);
            case (rq.op)
                OP_RELEASE, OP_UNPIN:
                begin
                    if (refs[e] == 0)
                    begin
                        r.needs_read = !dv[e];
                        r.status = STAT_COUNT_ERR;
                        return r;
                    end
                    refs[e] = refs[e] - 8'd1;
                    if (rq.op == OP_RELEASE && refs[e] == 0)
                        rel_time[e] = rq.now;
                end
                OP_PIN:
                begin
                    if (refs[e] == REFS_MAX)
                    begin
                        r.needs_read = !dv[e];
                        r.ref_count = refs[e];
                        r.status = STAT_COUNT_ERR;
                        return r;
                    end
                    refs[e] = refs[e] + 8'd1;
                end
                OP_MARK_VALID:
                    dv[e] = 1'b1;
                default:
                    ;
            endcase
            r.needs_read = !dv[e];
            r.ref_count = refs[e];
            return r;
        endfunction

        function void note_request(req_t rq);
            rsp_t r;
            r = apply_request(rq);
            pending_rsp.push_back(r);
            if (rq.op == OP_GET && r.hit)
                n_hit++;
            if (rq.op == OP_GET && !r.hit && r.status == STAT_OK)
                n_alloc++;
            if (r.status == STAT_NO_FREE)
                n_full++;
            if (r.status == STAT_COUNT_ERR)
                n_count_err++;
        endfunction

        function void check_response(rsp_t act);
            rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                $error("response with nothing pending: slot %0d status %0d",
                       act.slot, act.status);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            n_checked++;
            if (act.slot !== want.slot)
            begin
                $error("slot: expected %0d, got %0d", want.slot, act.slot);
                errors++;
            end
            if (act.hit !== want.hit)
            begin
                $error("hit: expected %0d, got %0d", want.hit, act.hit);
                errors++;
            end
            if (act.needs_read !== want.needs_read)
            begin
                $error("needs_read: expected %0d, got %0d", want.needs_read, act.needs_read);
                errors++;
            end
            if (act.ref_count !== want.ref_count)
            begin
                $error("ref_count: expected %0d, got %0d", want.ref_count, act.ref_count);
                errors++;
            end
            if (act.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, act.status);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bbc_req_if req_ch ();
    bbc_rsp_if rsp_ch ();

    block_buffer_cache_lru #(
        .BUFFERS(N_BUF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    cache_scoreboard sb = new();
    int n_sent = 0;
    int burst_left = 0;
    int rx_tick = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic req_t mk_req(logic [2:0] op, logic [15:0] dev, logic [31:0] blk,
                                    logic [4:0] ent, logic [31:0] stamp);
        req_t r;
        r.op = op;
        r.device = dev;
        r.blk = blk;
        r.entry = ent;
        r.now = stamp;
        return r;
    endfunction

    function automatic logic [31:0] pick_stamp();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 32'hFFFF_FFFF;
        if (sel == 1)
            return 32'h0;
        if (sel < 4)
            return $urandom_range(0, 15);
        return $urandom;
    endfunction

    // small tag pool so gets hit often, with the extremes mixed in
    function automatic logic [15:0] pick_dev();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 16'hFFFF;
        if (sel == 1)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 2));
    endfunction

    function automatic logic [31:0] pick_blk();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 32'hFFFF_FFFF;
        if (sel == 1)
            return $urandom;
        return $urandom_range(0, 7);
    endfunction

    function automatic int pick_busy_entry();
        int start;
        int idx;
        start = $urandom_range(0, N_BUF - 1);
        for (int k = 0; k < N_BUF; k++)
        begin
            idx = (start + k) % N_BUF;
            if (sb.refs[idx] != 0)
                return idx;
        end
        return $urandom_range(0, N_BUF - 1);
    endfunction

    function automatic int free_entries();
        int cnt;
        cnt = 0;
        foreach (sb.refs[i])
            if (sb.refs[i] == 0)
                cnt++;
        return cnt;
    endfunction

    function automatic req_t mixed_req();
        int sel;
        logic [2:0] rsvd [3];
        rsvd[0] = OP_RSVD_LO;
        rsvd[1] = OP_RSVD_MID;
        rsvd[2] = OP_RSVD_HI;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return mk_req(OP_GET, pick_dev(), pick_blk(), 5'($urandom_range(0, 31)),
                          pick_stamp());
        if (sel < 65)
            return mk_req(OP_RELEASE, 16'($urandom), $urandom, 5'(pick_busy_entry()),
                          pick_stamp());
        if (sel < 73)
            return mk_req(OP_PIN, 16'($urandom), $urandom, 5'($urandom_range(0, 31)),
                          pick_stamp());
        if (sel < 80)
            return mk_req(OP_UNPIN, 16'($urandom), $urandom, 5'(pick_busy_entry()),
                          pick_stamp());
        if (sel < 90)
            return mk_req(OP_MARK_VALID, 16'($urandom), $urandom, 5'($urandom_range(0, 31)),
                          pick_stamp());
        // noise: count operations on arbitrary entries, undefined ops
        if (sel < 94)
            return mk_req(OP_RELEASE, 16'($urandom), $urandom, 5'($urandom_range(0, 31)),
                          pick_stamp());
        if (sel < 97)
            return mk_req(OP_UNPIN, 16'($urandom), $urandom, 5'($urandom_range(0, 31)),
                          pick_stamp());
        return mk_req(rsvd[$urandom_range(0, 2)], 16'($urandom), $urandom,
                      5'($urandom_range(0, 31)), $urandom);
    endfunction

    task automatic send_req(req_t rq);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 20);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.op <= rq.op;
        req_ch.device <= rq.device;
        req_ch.block_number <= rq.blk;
        req_ch.entry <= rq.entry;
        req_ch.now <= rq.now;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(rq);
        n_sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_mixed(int count);
        repeat (count) send_req(mixed_req());
    endtask

    // take every free entry with fresh tags, then miss on a full cache
    task automatic fill_cache();
        while (free_entries() != 0)
            send_req(mk_req(OP_GET, 16'($urandom_range(0, 65535)), $urandom, 5'd0,
                            $urandom));
        repeat (2)
            send_req(mk_req(OP_GET, 16'($urandom_range(0, 65535)), $urandom, 5'd31,
                            $urandom));
    endtask

    // release back to zero every entry whose count is below 200, stamping the all-ones time on about half
    task automatic drain_cache();
        logic [31:0] stamp;
        for (int i = 0; i < N_BUF; i++)
            while (sb.refs[i] != 0 && sb.refs[i] < 200)
            begin
                stamp = $urandom_range(0, 1) ? 32'hFFFF_FFFF : pick_stamp();
                send_req(mk_req(OP_RELEASE, 16'($urandom), $urandom, 5'(i), stamp));
            end
    endtask

    task automatic saturate_entry();
        int sat;
        sat = $urandom_range(0, N_BUF - 1);
        while (sb.refs[sat] != REFS_MAX)
            send_req(mk_req(OP_PIN, 16'($urandom), $urandom, 5'(sat), $urandom));
        send_req(mk_req(OP_PIN, 16'($urandom), $urandom, 5'(sat), $urandom));
        send_req(mk_req(OP_GET, sb.tag_dev[sat], sb.tag_blk[sat], 5'(sat), $urandom));
        send_req(mk_req(OP_UNPIN, 16'($urandom), $urandom, 5'(sat), $urandom));
        send_req(mk_req(OP_PIN, 16'($urandom), $urandom, 5'(sat), $urandom));
    endtask

    initial
    begin
        req_t directed [$];
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.op <= OP_GET;
        req_ch.device <= '0;
        req_ch.block_number <= '0;
        req_ch.entry <= '0;
        req_ch.now <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // every entry is tagged zero after reset: lowest index must win
        directed.push_back(mk_req(OP_GET, 16'h0, 32'h0, 5'd0, 32'h0));
        directed.push_back(mk_req(OP_GET, 16'h0, 32'h0, 5'd31, 32'h0));
        directed.push_back(mk_req(OP_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF));
        directed.push_back(mk_req(OP_MARK_VALID, 16'h0, 32'h0, 5'd1, 32'h0));
        directed.push_back(mk_req(OP_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd0, 32'h0));
        directed.push_back(mk_req(OP_RELEASE, 16'h0, 32'h0, 5'd31, 32'h5));
        directed.push_back(mk_req(OP_UNPIN, 16'h0, 32'h0, 5'd31, 32'h0));
        directed.push_back(mk_req(OP_PIN, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF));
        directed.push_back(mk_req(OP_UNPIN, 16'h0, 32'h0, 5'd31, 32'h0));
        directed.push_back(mk_req(OP_RELEASE, 16'h0, 32'h0, 5'd0, 32'hFFFF_FFFF));
        directed.push_back(mk_req(OP_RELEASE, 16'h0, 32'h0, 5'd0, 32'hFFFF_FFFF));
        directed.push_back(mk_req(OP_RELEASE, 16'h0, 32'h0, 5'd1, 32'h1234_5678));
        directed.push_back(mk_req(OP_RSVD_LO, 16'hFFFF, 32'hFFFF_FFFF, 5'd1, 32'hFFFF_FFFF));
        directed.push_back(mk_req(OP_RSVD_MID, 16'h0, 32'h0, 5'd0, 32'h0));
        directed.push_back(mk_req(OP_RSVD_HI, 16'h0, 32'h0, 5'd31, 32'h0));
        directed.push_back(mk_req(OP_GET, 16'h1234, 32'hDEAD_BEEF, 5'd0, 32'h0));
        directed.push_back(mk_req(OP_MARK_VALID, 16'h0, 32'h0, 5'd31, 32'h0));
        directed.push_back(mk_req(OP_RSVD_LO, 16'h0, 32'h0, 5'd31, 32'h0));
        directed.push_back(mk_req(OP_PIN, 16'h0, 32'h0, 5'd2, 32'h0));
        directed.push_back(mk_req(OP_RELEASE, 16'h0, 32'h0, 5'd2, 32'h0));
        directed.push_back(mk_req(OP_RELEASE, 16'h0, 32'h0, 5'd2, 32'h0000_0007));
        // freed entry zero still holds its tag, so this hits it and raises its count from zero to one
        directed.push_back(mk_req(OP_GET, 16'h0, 32'h0, 5'd0, 32'h0));
        foreach (directed[i])
            send_req(directed[i]);
        wait_drained();

        run_mixed(MIXED_RUN);
        fill_cache();
        drain_cache();
        run_mixed(MIXED_RUN);
        wait_drained();
        saturate_entry();
        run_mixed(MIXED_RUN);
        fill_cache();
        drain_cache();
        while (n_sent < TARGET_ITEMS)
            send_req(mixed_req());

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d items: %0d hits, %0d allocations, %0d full-cache misses",
                 n_sent, sb.n_hit, sb.n_alloc, sb.n_full);
        $display("%0d results checked, %0d count errors seen, %0d mismatches",
                 sb.n_checked, sb.n_count_err, sb.errors);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result side: always ready, coin flip, or mostly stalled, in turns
    initial
    begin
        rsp_t act;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                act.slot = rsp_ch.slot;
                act.hit = rsp_ch.hit;
                act.needs_read = rsp_ch.needs_read;
                act.ref_count = rsp_ch.ref_count;
                act.status = rsp_ch.status;
                sb.check_response(act);
            end
            rx_tick++;
            case ((rx_tick / 300) % 3)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                default: rsp_ch.ready <= (rx_tick % 7 == 0);
            endcase
        end
    end

    initial
    begin
        #4_000_000;
        $error("timeout with %0d results pending", sb.pending_rsp.size());
        $display("status: fail");
        $finish;
    end

endmodule
